@@ design/nsfd_pkg.sv @@
// Package for the H.264 Annex B NAL splitter with frame detection.
// Holds the word types, NAL type codes and stream constants.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package nsfd_pkg;

    // Default width of the unit byte counter
    localparam int unsigned LENGTH_BITS_DEF = 24;

    // Width of the reported length field
    localparam int unsigned NAL_LEN_W = 24;

    // Header capture depth in bytes
    localparam int unsigned HDR_BYTES = 8;

    // Start code bytes and prefix history after reset
    localparam logic [7:0]  START_BYTE   = 8'h01;
    localparam logic [7:0]  ZERO_BYTE    = 8'h00;
    localparam logic [15:0] PREFIX_RESET = 16'hFFFF;

    // NAL unit type codes
    localparam logic [4:0] NAL_TYPE_SLICE      = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR        = 5'd5;
    localparam logic [4:0] NAL_TYPE_SEI        = 5'd6;
    localparam logic [4:0] NAL_TYPE_SPS        = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS        = 5'd8;
    localparam logic [4:0] NAL_TYPE_PREFIX     = 5'd14;
    localparam logic [4:0] NAL_TYPE_SUBSET_SPS = 5'd15;
    localparam logic [4:0] NAL_TYPE_SVC_SLICE  = 5'd20;

    // Header length in bytes for plain and extended units
    localparam logic [2:0] HDR_LEN_PLAIN = 3'd1;
    localparam logic [2:0] HDR_LEN_EXT   = 3'd4;

    // Input word: one stream byte or an end-of-stream mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    // Result word: one closed NAL unit
    typedef struct packed {
        logic [4:0]           unit_type;
        logic [1:0]           ref_idc;
        logic [NAL_LEN_W-1:0] nal_length;
        logic [15:0]          first_mb;
        logic                 first_mb_valid;
        logic                 starts_new_frame;
        logic                 svc_unsupported;
        logic                 keep_unit;
        logic                 stream_end;
    } t_out_word;

    // Closed unit handed from the parser to the decoder
    typedef struct packed {
        logic                   eos;
        logic [8*HDR_BYTES-1:0] header;
    } t_close;

endpackage

`default_nettype wire

@@ design/nsfd_parse.sv @@
// Start code scanner: tracks the byte history, counts unit bytes and
// captures the header bytes; registers a closed unit for the decoder.
// Depends on nsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsfd_parse #(
    parameter int unsigned LENGTH_BITS = nsfd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_advance,
    input  wire logic                   i_in_valid,
    input  nsfd_pkg::t_in_word          i_in_word,
    output logic                        o_cl_valid,
    output nsfd_pkg::t_close            o_cl,
    output logic [LENGTH_BITS-1:0]      o_cl_len
);
    import nsfd_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CountMax = '1;

    logic [15:0]            r_prefix, n_prefix;
    logic                   r_start_seen, n_start_seen;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [LENGTH_BITS-1:0] r_lnz, n_lnz;
    logic [8*HDR_BYTES-1:0] r_hdr, n_hdr;

    logic                   r_cl_valid, n_close;
    t_close                 r_cl, n_cl;
    logic [LENGTH_BITS-1:0] r_cl_len, n_cl_len;

    logic                   match;
    logic [7:0]             in_byte;

    assign in_byte = i_in_word.data_byte;

    // Next scanner state and closed-unit snapshot
    always_comb begin
        n_prefix     = r_prefix;
        n_start_seen = r_start_seen;
        n_count      = r_count;
        n_lnz        = r_lnz;
        n_hdr        = r_hdr;
        n_close      = 1'b0;
        n_cl.eos     = 1'b0;
        n_cl.header  = r_hdr;
        n_cl_len     = '0;
        match        = 1'b0;
        if (i_in_valid) begin
            if (i_in_word.end_of_stream) begin
                // close the open unit untrimmed and return to reset state
                n_close      = 1'b1;
                n_cl.eos     = 1'b1;
                n_cl_len     = r_start_seen ? r_count : '0;
                n_prefix     = PREFIX_RESET;
                n_start_seen = 1'b0;
                n_count      = '0;
                n_lnz        = '0;
                n_hdr        = '0;
            end else begin
                if (r_start_seen) begin
                    for (int k = 0; k < HDR_BYTES; k++) begin
                        if (r_count == LENGTH_BITS'(k)) begin
                            n_hdr[8*k +: 8] = in_byte;
                        end
                    end
                    if (r_count != CountMax) begin
                        n_count = r_count + 1'b1;
                    end
                    if (in_byte != ZERO_BYTE) begin
                        n_lnz = n_count;
                    end
                end
                match    = (r_prefix == {ZERO_BYTE, ZERO_BYTE}) && (in_byte == START_BYTE);
                n_prefix = {r_prefix[7:0], in_byte};
                if (match) begin
                    if (r_start_seen) begin
                        // trimmed length: last nonzero byte before this start code
                        n_close     = 1'b1;
                        n_cl_len    = r_lnz;
                        n_cl.header = n_hdr;
                    end
                    n_start_seen = 1'b1;
                    n_count      = '0;
                    n_lnz        = '0;
                    n_hdr        = '0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix     <= PREFIX_RESET;
            r_start_seen <= 1'b0;
            r_count      <= '0;
            r_lnz        <= '0;
            r_hdr        <= '0;
            r_cl_valid   <= 1'b0;
        end else if (i_advance) begin
            r_prefix     <= n_prefix;
            r_start_seen <= n_start_seen;
            r_count      <= n_count;
            r_lnz        <= n_lnz;
            r_hdr        <= n_hdr;
            r_cl_valid   <= n_close;
        end
    end

    // Snapshot payload
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_cl     <= n_cl;
            r_cl_len <= n_cl_len;
        end
    end

    assign o_cl_valid = r_cl_valid;
    assign o_cl       = r_cl;
    assign o_cl_len   = r_cl_len;

endmodule

`default_nettype wire

@@ design/nsfd_decode.sv @@
// Header decoder: extracts type and ref_idc, handles the SVC extension,
// decodes the first macroblock index and flags new frames into the result register.
// Depends on nsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsfd_decode #(
    parameter int unsigned LENGTH_BITS = nsfd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_advance,
    input  wire logic                   i_cl_valid,
    input  nsfd_pkg::t_close            i_cl,
    input  wire logic [LENGTH_BITS-1:0] i_cl_len,
    output logic                        o_out_valid,
    output nsfd_pkg::t_out_word         o_out_word
);
    import nsfd_pkg::*;

    logic        r_out_valid;
    t_out_word   r_out, n_out;
    logic        r_pending;

    logic [3:0]  len_clip;
    logic [7:0]  hb [HDR_BYTES];
    logic [4:0]  raw_type, unit_type;
    logic        ext, svc, keep, is_slice, fits, mb_valid;
    logic [2:0]  hdr_len, avail;
    logic [3:0]  diff;
    logic [31:0] code_word, shifted;
    logic [4:0]  lz, shamt;
    logic [15:0] mask, fmb;

    // Clip the length so header bytes at or past it read as zero
    assign len_clip = (|i_cl_len[LENGTH_BITS-1:4]) ? 4'd15 : i_cl_len[3:0];

    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            hb[k] = (len_clip > 4'(k)) ? i_cl.header[8*k +: 8] : ZERO_BYTE;
        end
    end

    // Type, ref_idc and the SVC extension
    assign raw_type  = hb[0][4:0];
    assign ext       = (raw_type == NAL_TYPE_PREFIX) || (raw_type == NAL_TYPE_SVC_SLICE);
    assign svc       = ext && hb[1][7];
    assign unit_type = (ext && !svc && raw_type == NAL_TYPE_SVC_SLICE) ? NAL_TYPE_SLICE
                                                                       : raw_type;
    assign keep      = !svc && (unit_type == NAL_TYPE_SLICE || unit_type == NAL_TYPE_IDR ||
                                unit_type == NAL_TYPE_SEI || unit_type == NAL_TYPE_SPS ||
                                unit_type == NAL_TYPE_PPS || unit_type == NAL_TYPE_PREFIX ||
                                unit_type == NAL_TYPE_SUBSET_SPS ||
                                unit_type == NAL_TYPE_SVC_SLICE);
    assign is_slice  = !svc && (unit_type == NAL_TYPE_SLICE || unit_type == NAL_TYPE_IDR);
    assign hdr_len   = ext ? HDR_LEN_EXT : HDR_LEN_PLAIN;

    // Four payload bytes after the header, big-endian
    assign code_word = ext ? {hb[4], hb[5], hb[6], hb[7]} : {hb[1], hb[2], hb[3], hb[4]};

    // Payload bytes inside the unit, at most four
    always_comb begin
        diff  = len_clip - {1'b0, hdr_len};
        avail = 3'd0;
        if (len_clip > {1'b0, hdr_len}) begin
            avail = (diff > 4'd4) ? 3'd4 : diff[2:0];
        end
    end

    // Leading zeros in the upper half; 16 means too many
    always_comb begin
        lz = 5'd16;
        for (int k = 0; k < 16; k++) begin
            if (code_word[16+k]) begin
                lz = 5'(15 - k);
            end
        end
    end

    // Exp-Golomb value: (1 << z) - 1 + info bits
    assign fits     = !lz[4] && ({lz, 1'b1} <= {avail, 3'b000});
    assign shamt    = 5'd31 - {lz[3:0], 1'b0};
    assign shifted  = code_word >> shamt;
    assign mask     = (16'h0001 << lz[3:0]) - 16'h0001;
    assign fmb      = mask + (shifted[15:0] & mask);
    assign mb_valid = is_slice && fits;

    always_comb begin
        n_out.unit_type        = unit_type;
        n_out.ref_idc          = hb[0][6:5];
        n_out.nal_length       = NAL_LEN_W'(i_cl_len);
        n_out.first_mb         = mb_valid ? fmb : 16'h0000;
        n_out.first_mb_valid   = mb_valid;
        n_out.starts_new_frame = mb_valid && !r_pending && (fmb == 16'h0000);
        n_out.svc_unsupported  = svc;
        n_out.keep_unit        = keep;
        n_out.stream_end       = i_cl.eos;
    end

    // Result valid and first-slice tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pending   <= 1'b1;
        end else if (i_advance) begin
            r_out_valid <= i_cl_valid;
            if (i_cl_valid) begin
                if (i_cl.eos) begin
                    r_pending <= 1'b1;
                end else if (mb_valid) begin
                    r_pending <= 1'b0;
                end
            end
        end
    end

    // Hold the result payload while stalled
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

@@ design/h264_nal_splitter_frame_detect_unit.sv @@
// Top level of the H.264 Annex B NAL splitter with frame detection.
// Holds the input register and the pipeline advance; uses nsfd_parse,
// nsfd_decode and nsfd_pkg.
//
//   channel  direction  handshake                 word
//   input    in         i_in_valid / o_in_stall   i_in_word  (t_in_word)
//   output   out        o_out_valid / i_out_stall o_out_word (t_out_word)
//
// One byte per clock is accepted while o_in_stall is low; the byte or
// end-of-stream mark that closes a unit passes the input register, the
// scanner snapshot and the result register before its result is valid.
// The three stages advance together; o_in_stall rises only while a result
// waits in the output register and the receiver stalls.
// Reset clears all scanner state and valid bits.
`timescale 1ns / 1ps
`default_nettype none

module h264_nal_splitter_frame_detect_unit #(
    parameter int unsigned LENGTH_BITS = nsfd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  nsfd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output nsfd_pkg::t_out_word o_out_word
);
    import nsfd_pkg::*;

    logic                   r_in_valid;
    t_in_word               r_in;
    logic                   advance;
    logic                   cl_valid;
    t_close                 cl;
    logic [LENGTH_BITS-1:0] cl_len;
    logic                   out_valid;

    // Advance all stages unless a result is held by the receiver
    assign advance    = !out_valid || !i_out_stall;
    assign o_in_stall = !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in <= i_in_word;
        end
    end

    nsfd_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_in_valid (r_in_valid),
        .i_in_word  (r_in),
        .o_cl_valid (cl_valid),
        .o_cl       (cl),
        .o_cl_len   (cl_len)
    );

    nsfd_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_cl_valid  (cl_valid),
        .i_cl        (cl),
        .i_cl_len    (cl_len),
        .o_out_valid (out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_out_valid = out_valid;

endmodule

`default_nettype wire

@@ design/nsfd_checker.sv @@
// Port-level checks for the NAL splitter top level, with the bind that
// attaches them. Depends on nsfd_pkg and h264_nal_splitter_frame_detect_unit.
`timescale 1ns / 1ps
`default_nettype none

module nsfd_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input nsfd_pkg::t_in_word  i_in_word,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input nsfd_pkg::t_out_word o_out_word
);
    import nsfd_pkg::*;

    // Hold a stalled input word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed");

    // Hold a stalled result word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // Stall the input only behind a held result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // A new frame needs a decoded zero first_mb
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.starts_new_frame |->
            o_out_word.first_mb_valid && (o_out_word.first_mb == 16'h0000))
        else $error("new frame without a decoded zero first_mb");

    // An unsupported SVC unit is neither kept nor decoded
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.svc_unsupported |->
            !o_out_word.keep_unit && !o_out_word.first_mb_valid)
        else $error("svc unit kept or decoded");

endmodule

bind h264_nal_splitter_frame_detect_unit nsfd_checker u_nsfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
